[rtl/cjs_pkg.sv]
// shared types and constants for the coalescing job stack
package cjs_pkg;

    localparam int STACK_DEPTH     = 16;
    localparam int TYPE_BITS       = 4;
    localparam int DESCRIPTOR_BITS = 16;
    localparam int MODE_BITS       = 2;
    localparam int COUNT_BITS      = $clog2(STACK_DEPTH + 1);

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef struct packed
    {
        func_t                      func;
        logic [TYPE_BITS-1:0]       job_type;
        logic [DESCRIPTOR_BITS-1:0] descriptor_id;
        logic [MODE_BITS-1:0]       convert_mode;
    } req_t;

    typedef struct packed
    {
        logic                       was_new;
        logic                       full_refused;
        logic                       pop_valid;
        logic [TYPE_BITS-1:0]       out_type;
        logic [DESCRIPTOR_BITS-1:0] out_descriptor;
        logic [MODE_BITS-1:0]       out_mode;
        logic [COUNT_BITS-1:0]      entry_count;
    } rsp_t;

    // one stored job
    typedef struct packed
    {
        logic                       valid;
        logic [TYPE_BITS-1:0]       jtype;
        logic [DESCRIPTOR_BITS-1:0] desc;
        logic [MODE_BITS-1:0]       mode;
    } entry_t;

    // match search running from the top cell downward
    typedef struct packed
    {
        logic                 hit;
        logic [MODE_BITS-1:0] mode;
    } scan_t;

    // per-transaction control broadcast to every cell
    typedef struct packed
    {
        logic push;
        logic any_hit;
        logic pop;
    } cell_ctrl_t;

endpackage

[rtl/cjs_cell.sv]
// one stack cell: holds an entry, compares it, shifts with its neighbors
module cjs_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  cjs_pkg::cell_ctrl_t                ctrl,
    input  logic [cjs_pkg::TYPE_BITS-1:0]       key_type,
    input  logic [cjs_pkg::DESCRIPTOR_BITS-1:0] key_desc,
    input  cjs_pkg::entry_t                    up_entry,
    input  cjs_pkg::entry_t                    down_entry,
    input  cjs_pkg::scan_t                     scan_in,
    output cjs_pkg::scan_t                     scan_out,
    output cjs_pkg::entry_t                    entry
);
    import cjs_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;
    logic   match;
    logic   shift_down;

    assign match = valid_reg && (key_desc != '0) && (data_reg.jtype == key_type)
                   && (data_reg.desc == key_desc);

    always_comb
    begin
        scan_out.hit  = scan_in.hit | match;
        scan_out.mode = scan_in.hit ? scan_in.mode : data_reg.mode;
    end

    // on a coalesce only cells from the top down to the hit move
    assign shift_down = ctrl.push && (!ctrl.any_hit || !scan_in.hit);

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (shift_down)
        begin
            valid_next = up_entry.valid;
            data_next  = up_entry;
        end
        else if (ctrl.pop)
        begin
            valid_next = down_entry.valid;
            data_next  = down_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        entry       = data_reg;
        entry.valid = valid_reg;
    end

endmodule

[rtl/coalescing_job_stack.sv]
// top level of the coalescing job stack
//
// last-in-first-out job stack of STACK_DEPTH entries, top entry in cell 0.
// request channel req_valid/req_ready/req carries a push or a pop; every
// request gives exactly one response on rsp_valid/rsp_ready/rsp.
// a push whose type and non-zero descriptor match a stored job removes that
// job, closes the gap and places the job on top with the stricter mode.
// a new job pushed into a full stack is refused and the stack is unchanged.
// the response is registered when the request is taken.
// throughput: one request per cycle; each cell compares its entry and all
// cells shift together in the same cycle, the hit search ripples down the row.
// req_ready is high while the response register is empty or being drained,
// so a stalled receiver holds off new requests after one pending response.
// reset empties the stack and drops any pending response.
module coalescing_job_stack
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  cjs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cjs_pkg::rsp_t rsp
);
    import cjs_pkg::*;

    entry_t                cells [STACK_DEPTH];
    scan_t                 scan  [STACK_DEPTH+1];
    cell_ctrl_t            ctrl;
    entry_t                new_entry;
    entry_t                empty_entry;
    logic                  accept;
    logic                  is_push;
    logic                  full;
    logic                  refused;
    logic [MODE_BITS-1:0]  merged_mode;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign is_push   = (req.func == FUNC_PUSH);
    assign full      = (count_reg == COUNT_BITS'(STACK_DEPTH));

    assign scan[0] = '0;

    assign refused = is_push && !scan[STACK_DEPTH].hit && full;

    always_comb
    begin
        ctrl.push    = accept && is_push && !refused;
        ctrl.any_hit = scan[STACK_DEPTH].hit;
        ctrl.pop     = accept && !is_push && (count_reg != '0);
    end

    assign merged_mode = (scan[STACK_DEPTH].hit && scan[STACK_DEPTH].mode < req.convert_mode)
                         ? scan[STACK_DEPTH].mode : req.convert_mode;

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.jtype = req.job_type;
        new_entry.desc  = req.descriptor_id;
        new_entry.mode  = merged_mode;
        empty_entry     = '0;
    end

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        entry_t up_e;
        entry_t down_e;

        if (i == 0)
        begin : g_top
            assign up_e = new_entry;
        end
        else
        begin : g_mid
            assign up_e = cells[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign down_e = empty_entry;
        end
        else
        begin : g_inner
            assign down_e = cells[i+1];
        end

        cjs_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key_type   (req.job_type),
            .key_desc   (req.descriptor_id),
            .up_entry   (up_e),
            .down_entry (down_e),
            .scan_in    (scan[i]),
            .scan_out   (scan[i+1]),
            .entry      (cells[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.any_hit)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.entry_count  = count_next;
        if (is_push)
        begin
            rsp_next.was_new      = !scan[STACK_DEPTH].hit;
            rsp_next.full_refused = refused;
        end
        else if (count_reg != '0)
        begin
            rsp_next.pop_valid      = 1'b1;
            rsp_next.out_type       = cells[0].jtype;
            rsp_next.out_descriptor = cells[0].desc;
            rsp_next.out_mode       = cells[0].mode;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/cjs_checker.sv]
// port-level checks for the coalescing job stack and their bind
module cjs_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input cjs_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input cjs_pkg::rsp_t rsp
);
    import cjs_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // count never exceeds the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count <= COUNT_BITS'(STACK_DEPTH))
        else $error("entry count beyond depth");

    // a refused push is a new job against a full stack
    a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.full_refused
        |-> rsp.was_new && rsp.entry_count == COUNT_BITS'(STACK_DEPTH)
            && !rsp.pop_valid)
        else $error("bad refused push");

    // a returned pop carries no push flags
    a_pop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.pop_valid |-> !rsp.was_new && !rsp.full_refused
            && rsp.entry_count < COUNT_BITS'(STACK_DEPTH))
        else $error("bad pop response");

    // a request is taken whenever no response is waiting
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty response slot");

endmodule

bind coalescing_job_stack cjs_checker u_cjs_checker (.*);
